/* hw/rtl/bmk_seq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmk_seq_pkg
// Shared types, constants and the melody table for the buzzer kick sequencer.
// ----------------------------------------------------------------------------
package bmk_seq_pkg;

	localparam int NOTE_COUNT   = 8;
	localparam int ROM_DEPTH    = 8;
	localparam int NOTE_IDX_W   = $clog2(ROM_DEPTH);
	localparam int FREQ_W       = 10;
	localparam int DUR_W        = 16;
	localparam int TIME_W       = 32;
	localparam int LEN_W        = 16;
	localparam int SLOTS_W      = 8;
	localparam int PROD_W       = LEN_W + SLOTS_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_KICK_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KICK_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KICK_SLOTS    = 2'd2;

	localparam logic [15:0]        KICK_INTERVAL_RST = 16'd500;
	localparam logic [15:0]        KICK_LENGTH_RST   = 16'd100;
	localparam logic [7:0]         KICK_SLOTS_RST    = 8'd10;

	localparam logic [FREQ_W-1:0]  KICK_START_HZ = 10'd150;
	localparam logic [FREQ_W-1:0]  KICK_STEP_HZ  = 10'd15;
	localparam logic [FREQ_W-1:0]  KICK_FLOOR_HZ = 10'd40;
	localparam logic [SLOTS_W-1:0] KICK_SLOT_MAX = 8'd255;
	localparam logic [SLOTS_W-1:0] KICK_SLOT_FLOOR = 8'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_STEP
	} seq_state_t;

	function automatic logic [FREQ_W-1:0] rom_freq(input logic [NOTE_IDX_W-1:0] idx);
		logic [FREQ_W-1:0] f;
		case (idx)
			3'd0: f = 10'd262;
			3'd1: f = 10'd294;
			3'd2: f = 10'd330;
			3'd3: f = 10'd392;
			3'd4: f = 10'd440;
			3'd5: f = 10'd0;
			3'd6: f = 10'd440;
			3'd7: f = 10'd392;
			default: f = 10'd0;
		endcase
		return f;
	endfunction

	function automatic logic [DUR_W-1:0] rom_len(input logic [NOTE_IDX_W-1:0] idx);
		logic [DUR_W-1:0] d;
		case (idx)
			3'd0: d = 16'd300;
			3'd1: d = 16'd300;
			3'd2: d = 16'd300;
			3'd3: d = 16'd300;
			3'd4: d = 16'd600;
			3'd5: d = 16'd200;
			3'd6: d = 16'd400;
			3'd7: d = 16'd400;
			default: d = 16'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/buzzer_melody_kick_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_melody_kick_sequencer_top
// Millisecond-tick sequencer for a buzzer: kick drum sweep over a looping melody.
// ----------------------------------------------------------------------------
// Each accepted item is a millisecond timestamp and yields one result item with
// the speaker frequency, a tone-change flag and the kick state. The result item
// appears after the bit-serial divider that finds the kick slot length, the
// slot-time product and the update, in that order. item_ready is low meanwhile
// and rises again the cycle after the update, so the block takes no new item
// before the last one has been updated. The result waits in an output register;
// the update holds while that register is full and result_ready is low.
// Configuration writes take effect at once and belong between items.
// ----------------------------------------------------------------------------
module buzzer_melody_kick_sequencer_top
	import bmk_seq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic [TIME_W-1:0]     now_ms,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic [FREQ_W-1:0]          speaker_freq,
	output logic                       speaker_changed,
	output logic                       kick_busy
);

	seq_state_t state_q, state_d;

	logic [LEN_W-1:0]      kick_interval_q;
	logic [LEN_W-1:0]      kick_length_q;
	logic [SLOTS_W-1:0]    kick_slots_q;

	logic [NOTE_IDX_W-1:0] note_index_q, note_index_d;
	logic [TIME_W-1:0]     note_begin_q, note_begin_d;
	logic                  note_running_q, note_running_d;
	logic [TIME_W-1:0]     last_kick_q, last_kick_d;
	logic                  kick_running_q, kick_running_d;
	logic [TIME_W-1:0]     kick_begin_q, kick_begin_d;
	logic [SLOTS_W-1:0]    kick_slot_q, kick_slot_d;
	logic [FREQ_W-1:0]     cur_freq_q, cur_freq_d;
	logic                  changed_d;

	logic [TIME_W-1:0]     now_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  res_valid_q;
	logic                  res_changed_q;

	logic                  accept;
	logic                  div_done;
	logic [LEN_W-1:0]      slot_len;
	logic [SLOTS_W-1:0]    div_dsr;
	logic                  step_go;

	assign accept  = item_valid && item_ready;
	assign div_dsr = (kick_slots_q == '0) ? SLOTS_W'(1) : kick_slots_q;

	bmk_seq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (kick_length_q),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (slot_len)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_MUL;
			ST_MUL:  state_d = ST_STEP;
			ST_STEP: if (!res_valid_q || result_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		step_go    = 1'b0;
		case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_STEP: step_go = !res_valid_q || result_ready;
			default: begin
				item_ready = 1'b0;
				step_go    = 1'b0;
			end
		endcase
	end

	// one update of kick trigger, kick sweep and melody
	always_comb begin
		logic                  trig;
		logic [TIME_W-1:0]     elapsed;
		logic [PROD_W-1:0]     slot_time;
		logic [FREQ_W-1:0]     sweep_f;
		logic [NOTE_IDX_W-1:0] idx;
		logic [FREQ_W-1:0]     nf;
		logic [DUR_W-1:0]      nl;

		last_kick_d    = last_kick_q;
		kick_running_d = kick_running_q;
		kick_begin_d   = kick_begin_q;
		kick_slot_d    = kick_slot_q;
		cur_freq_d     = cur_freq_q;
		note_index_d   = note_index_q;
		note_begin_d   = note_begin_q;
		note_running_d = note_running_q;
		changed_d      = 1'b0;

		trig      = (now_q - last_kick_q) >= {16'd0, kick_interval_q};
		slot_time = prod_q;
		if (trig) begin
			last_kick_d    = now_q;
			kick_running_d = 1'b1;
			kick_begin_d   = now_q;
			kick_slot_d    = '0;
			slot_time      = '0;
		end

		elapsed = now_q - kick_begin_d;
		sweep_f = (kick_slot_d > KICK_SLOT_FLOOR) ? KICK_FLOOR_HZ :
			KICK_START_HZ - FREQ_W'(kick_slot_d[2:0]) * KICK_STEP_HZ;
		if (kick_running_d) begin
			if (elapsed >= {16'd0, kick_length_q}) begin
				kick_running_d = 1'b0;
				cur_freq_d     = '0;
				changed_d      = 1'b1;
			end else if (elapsed >= {8'd0, slot_time}) begin
				cur_freq_d = sweep_f;
				changed_d  = 1'b1;
				if (kick_slot_d != KICK_SLOT_MAX) kick_slot_d = kick_slot_d + 1'b1;
			end
		end

		idx = note_index_q;
		nf  = rom_freq(idx);
		nl  = rom_len(idx);
		if (!note_running_q) begin
			if (nf != '0 && !kick_running_d) begin
				cur_freq_d = nf;
				changed_d  = 1'b1;
			end
			note_begin_d   = now_q;
			note_running_d = 1'b1;
		end
		if ((now_q - note_begin_d) >= {16'd0, nl}) begin
			if (!kick_running_d) begin
				cur_freq_d = '0;
				changed_d  = 1'b1;
			end
			note_index_d   = (note_index_q == NOTE_IDX_W'(NOTE_COUNT - 1)) ? '0 :
				note_index_q + 1'b1;
			note_running_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			kick_interval_q <= KICK_INTERVAL_RST;
			kick_length_q   <= KICK_LENGTH_RST;
			kick_slots_q    <= KICK_SLOTS_RST;
			note_index_q    <= '0;
			note_begin_q    <= '0;
			note_running_q  <= 1'b0;
			last_kick_q     <= '0;
			kick_running_q  <= 1'b0;
			kick_begin_q    <= '0;
			kick_slot_q     <= '0;
			cur_freq_q      <= '0;
			res_valid_q     <= 1'b0;
			res_changed_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_KICK_INTERVAL: kick_interval_q <= cfg_data;
					CFG_KICK_LENGTH:   kick_length_q   <= cfg_data;
					CFG_KICK_SLOTS:    kick_slots_q    <= cfg_data[SLOTS_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) res_valid_q <= 1'b0;
			if (step_go) begin
				note_index_q   <= note_index_d;
				note_begin_q   <= note_begin_d;
				note_running_q <= note_running_d;
				last_kick_q    <= last_kick_d;
				kick_running_q <= kick_running_d;
				kick_begin_q   <= kick_begin_d;
				kick_slot_q    <= kick_slot_d;
				cur_freq_q     <= cur_freq_d;
				res_changed_q  <= changed_d;
				res_valid_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) now_q <= now_ms;
		if (state_q == ST_MUL) prod_q <= kick_slot_q * slot_len;
	end

	assign result_valid    = res_valid_q;
	assign speaker_freq    = cur_freq_q;
	assign speaker_changed = res_changed_q;
	assign kick_busy       = kick_running_q;

endmodule
`default_nettype wire

/* hw/rtl/bmk_seq_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmk_seq_div
// Restoring divider, one quotient bit per cycle, for the kick slot length.
// ----------------------------------------------------------------------------
module bmk_seq_div
	import bmk_seq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [LEN_W-1:0]   dividend,
	input  wire logic [SLOTS_W-1:0] divisor,
	output logic                    done,
	output logic [LEN_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(LEN_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SLOTS_W-1:0] rem_q;
	logic [LEN_W-1:0]   quo_q;
	logic [SLOTS_W-1:0] dsr_q;
	logic [SLOTS_W:0]   rem_sh;
	logic               fit;
	logic [SLOTS_W:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quo_q[LEN_W-1]};
		fit     = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(LEN_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? rem_sub[SLOTS_W-1:0] : rem_sh[SLOTS_W-1:0];
			quo_q <= {quo_q[LEN_W-2:0], fit};
		end
	end

	assign done     = busy_q && (cnt_q == CNT_W'(LEN_W - 1));
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* tb/buzzer_melody_kick_sequencer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_melody_kick_sequencer_top_tb
// Self-checking bench for the buzzer melody and kick drum sequencer.
// A short table of directed timestamps and register writes comes first. Then come phases of random
// timestamps, each under its own kick settings. Every accepted item is run
// through a local copy of the sequencer state. Each result item is checked
// field by field, in order. Both handshakes idle at random, and once the result
// side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module buzzer_melody_kick_sequencer_top_tb;
	import bmk_seq_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SQUEEZE_AT = 300;
	localparam int SQUEEZE_CYCLES = 600;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [FREQ_W-1:0] TUNE_HZ [ROM_DEPTH] = '{
		10'd262, 10'd294, 10'd330, 10'd392, 10'd440, 10'd0, 10'd440, 10'd392
	};
	localparam logic [DUR_W-1:0] TUNE_MS [ROM_DEPTH] = '{
		16'd300, 16'd300, 16'd300, 16'd300, 16'd600, 16'd200, 16'd400, 16'd400
	};

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic              changed;
		logic              busy;
	} tone_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [31:0]           value;
		bit                    typed;
		logic [FREQ_W-1:0]     freq;
		bit                    changed;
		bit                    busy;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_ready;
	logic [TIME_W-1:0]     now_ms;
	logic                  result_valid;
	logic                  result_ready;
	logic [FREQ_W-1:0]     speaker_freq;
	logic                  speaker_changed;
	logic                  kick_busy;

	buzzer_melody_kick_sequencer_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.now_ms         (now_ms),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.speaker_freq   (speaker_freq),
		.speaker_changed(speaker_changed),
		.kick_busy      (kick_busy)
	);

	always #1 clk = ~clk;

	// sequencer state as the bench sees it
	logic [15:0]        reg_interval = KICK_INTERVAL_RST;
	logic [15:0]        reg_length   = KICK_LENGTH_RST;
	logic [7:0]         reg_slots    = KICK_SLOTS_RST;
	logic [2:0]         tune_pos     = '0;
	logic [31:0]        tune_start   = '0;
	bit                 tune_on      = 1'b0;
	logic [31:0]        kick_last    = '0;
	bit                 kick_on      = 1'b0;
	logic [31:0]        kick_start   = '0;
	logic [7:0]         kick_step    = '0;
	logic [FREQ_W-1:0]  tone_hz      = '0;

	tone_t tone_expected [$];
	tone_t want;
	logic [31:0] tick_ms;
	int items_sent = 0;
	int results_seen = 0;
	int writes_done = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit squeeze_done = 1'b0;

	stim_row_t directed_rows [33] = '{
		'{ROW_ITEM, '0, 32'd0,          1'b1, 10'd262, 1'b1, 1'b0},
		'{ROW_ITEM, '0, 32'd1,          1'b1, 10'd262, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd300,        1'b1, 10'd0,   1'b1, 1'b0},
		'{ROW_ITEM, '0, 32'd301,        1'b1, 10'd294, 1'b1, 1'b0},
		'{ROW_ITEM, '0, 32'd500,        1'b1, 10'd150, 1'b1, 1'b1},
		'{ROW_ITEM, '0, 32'd510,        1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd600,        1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_LENGTH,   32'd0,     1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd1100,       1'b1, 10'd0,   1'b1, 1'b0},
		'{ROW_CFG,  CFG_KICK_SLOTS,    32'd0,     1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_LENGTH,   32'd100,   1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_INTERVAL, 32'd0,     1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd1101,       1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd1150,       1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_INTERVAL, 32'd65535, 1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_SLOTS,    32'd200,   1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd70000,      1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd70001,      1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'd70002,      1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_LENGTH,   32'd65535, 1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_SLOTS,    32'd255,   1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'hFFFF_FFFF,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'h0000_0000,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'h7FFF_FFFF,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'h8000_0000,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'hAAAA_AAAA,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'h5555_5555,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_UNUSED,        32'hFFFF,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_INTERVAL, 32'd0,     1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_LENGTH,   32'd1,     1'b0, '0, 1'b0, 1'b0},
		'{ROW_CFG,  CFG_KICK_SLOTS,    32'd1,     1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'h5555_5556,  1'b0, '0, 1'b0, 1'b0},
		'{ROW_ITEM, '0, 32'h5555_5557,  1'b0, '0, 1'b0, 1'b0}
	};

	// one millisecond update: kick trigger, kick sweep, then melody
	function automatic tone_t advance_sequencer(input logic [31:0] t);
		tone_t r;
		logic [31:0] since;
		logic [15:0] slot_ms;
		logic [23:0] slot_at;
		logic [11:0] drop;
		logic [2:0] pos;
		r.changed = 1'b0;
		since = t - kick_last;
		if (since >= {16'd0, reg_interval}) begin
			kick_last = t;
			kick_on = 1'b1;
			kick_start = t;
			kick_step = '0;
		end
		if (kick_on) begin
			since = t - kick_start;
			if (since >= {16'd0, reg_length}) begin
				kick_on = 1'b0;
				tone_hz = '0;
				r.changed = 1'b1;
			end else begin
				slot_ms = reg_length / ((reg_slots == 8'd0) ? 16'd1 : {8'd0, reg_slots});
				slot_at = kick_step * slot_ms;
				if (since >= {8'd0, slot_at}) begin
					drop = kick_step * KICK_STEP_HZ;
					if (drop + KICK_FLOOR_HZ > KICK_START_HZ)
						tone_hz = KICK_FLOOR_HZ;
					else
						tone_hz = KICK_START_HZ - 10'(drop);
					r.changed = 1'b1;
					if (kick_step != KICK_SLOT_MAX)
						kick_step = kick_step + 8'd1;
				end
			end
		end
		pos = tune_pos;
		if (!tune_on) begin
			if (TUNE_HZ[pos] != '0 && !kick_on) begin
				tone_hz = TUNE_HZ[pos];
				r.changed = 1'b1;
			end
			tune_start = t;
			tune_on = 1'b1;
		end
		since = t - tune_start;
		if (since >= {16'd0, TUNE_MS[pos]}) begin
			if (!kick_on) begin
				tone_hz = '0;
				r.changed = 1'b1;
			end
			tune_pos = (tune_pos == 3'(NOTE_COUNT - 1)) ? 3'd0 : tune_pos + 3'd1;
			tune_on = 1'b0;
		end
		r.freq = tone_hz;
		r.busy = kick_on;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// mostly forward steps, with jumps, stray stamps and steps back as noise
	function automatic logic [31:0] next_stamp(input logic [31:0] t, input int max_step,
			input bit noisy);
		int roll;
		roll = $urandom_range(0, 99);
		if (noisy && roll < 5)
			return $urandom;
		if (noisy && roll < 9)
			return t + $urandom_range(500, 70000);
		if (noisy && roll < 11)
			return t - $urandom_range(1, 50);
		return t + $urandom_range(0, max_step);
	endfunction

	task automatic settle();
		item_valid <= 1'b0;
		while (tone_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KICK_INTERVAL: reg_interval = data;
			CFG_KICK_LENGTH: reg_length = data;
			CFG_KICK_SLOTS: reg_slots = data[7:0];
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic send_stamp(input logic [31:0] t, input bit typed, input tone_t typed_want);
		int gap;
		tone_t forecast;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		now_ms <= t;
		do @(posedge clk); while (!item_ready);
		forecast = advance_sequencer(t);
		tone_expected.push_back(typed ? typed_want : forecast);
		items_sent++;
	endtask

	task automatic run_phase(input logic [15:0] interval, input logic [15:0] length,
			input logic [7:0] slots, input int count, input int max_step, input bit noisy);
		program_reg(CFG_KICK_INTERVAL, interval);
		program_reg(CFG_KICK_LENGTH, length);
		program_reg(CFG_KICK_SLOTS, {8'd0, slots});
		// a jump past any interval so each phase opens on a fresh kick
		tick_ms = tick_ms + 32'd70000;
		send_stamp(tick_ms, 1'b0, '0);
		repeat (count - 1) begin
			tick_ms = next_stamp(tick_ms, max_step, noisy);
			send_stamp(tick_ms, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_valid <= 1'b0;
		now_ms <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				program_reg(directed_rows[i].reg_idx, directed_rows[i].value[15:0]);
			else
				send_stamp(directed_rows[i].value, directed_rows[i].typed,
					{directed_rows[i].freq, directed_rows[i].changed, directed_rows[i].busy});
		end
		tick_ms = 32'h5555_5557;

		run_phase(16'd500, 16'd100, 8'd10, 120, 12, 1'b1);
		run_phase(16'd200, 16'd150, 8'd15, 80, 8, 1'b1);
		// steps of at most one ms walk the slot counter far along a long kick
		run_phase(16'd65535, 16'd400, 8'd255, 280, 1, 1'b0);
		run_phase(16'd0, 16'd0, 8'd0, 40, 20, 1'b1);
		run_phase(16'd50, 16'd65535, 8'd1, 40, 40, 1'b1);
		run_phase(16'd1000, 16'd30, 8'd100, 50, 5, 1'b1);
		// cross the 32 bit wrap of the timestamp
		tick_ms = 32'hFFFE_E700;
		run_phase(16'd700, 16'd120, 8'd8, 100, 50, 1'b0);
		repeat (2)
			run_phase(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 500)),
				8'($urandom_range(0, 255)), 30, 30, 1'b1);

		settle();
		repeat (40) @(posedge clk);
		$display("covered %0d timestamps under %0d register writes: kicks, sweeps, rests, wraps",
			items_sent, writes_done);
		$display("checked %0d result items, %0d mismatches, %0d still expected",
			results_seen, mismatches, tone_expected.size());
		if (mismatches == 0 && tone_expected.size() == 0)
			$display("buzzer_melody_kick_sequencer_top verification clean");
		else
			$display("buzzer_melody_kick_sequencer_top verification failed");
		$finish;
	end

	initial begin : result_side
		int run_len;
		int gap;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
				squeeze_done = 1'b1;
				result_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end
			run_len = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
			result_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (tone_expected.size() == 0) begin
				$display("%0t ns: result item with nothing expected, freq %0d changed %0b busy %0b",
					$time, speaker_freq, speaker_changed, kick_busy);
				mismatches++;
			end else begin
				want = tone_expected.pop_front();
				if (speaker_freq !== want.freq) begin
					$display("%0t ns: speaker_freq expected %0d, got %0d",
						$time, want.freq, speaker_freq);
					mismatches++;
				end
				if (speaker_changed !== want.changed) begin
					$display("%0t ns: speaker_changed expected %0b, got %0b",
						$time, want.changed, speaker_changed);
					mismatches++;
				end
				if (kick_busy !== want.busy) begin
					$display("%0t ns: kick_busy expected %0b, got %0b",
						$time, want.busy, kick_busy);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("buzzer_melody_kick_sequencer_top verification failed");
			$finish;
		end
	end

endmodule

/* buzzer_melody_kick_sequencer_top.f */
hw/rtl/bmk_seq_pkg.sv
hw/rtl/bmk_seq_div.sv
hw/rtl/buzzer_melody_kick_sequencer_top.sv
tb/buzzer_melody_kick_sequencer_top_tb.sv
